// File: rtl/urxf_pkg.sv
// Shared types and constants for the UART register block with receive FIFO.
// Holds the register map, bit positions, request/response payloads and the
// FIFO control/status structs. No dependencies.
package urxf_pkg;

  // Default receive FIFO depth.
  localparam int RX_DEPTH_DEF = 16;

  // Request kinds.
  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_RXBYTE = 2'd2
  } opcode_t;

  // Register byte offsets.
  localparam logic [11:0] OFF_DATA  = 12'h000;
  localparam logic [11:0] OFF_RSR   = 12'h004;
  localparam logic [11:0] OFF_FLAG  = 12'h018;
  localparam logic [11:0] OFF_IRDA  = 12'h020;
  localparam logic [11:0] OFF_IBRD  = 12'h024;
  localparam logic [11:0] OFF_FBRD  = 12'h028;
  localparam logic [11:0] OFF_LCR   = 12'h02C;
  localparam logic [11:0] OFF_CR    = 12'h030;
  localparam logic [11:0] OFF_IFLS  = 12'h034;
  localparam logic [11:0] OFF_IMSC  = 12'h038;
  localparam logic [11:0] OFF_RIS   = 12'h03C;
  localparam logic [11:0] OFF_MIS   = 12'h040;
  localparam logic [11:0] OFF_ICR   = 12'h044;
  localparam logic [11:0] OFF_DMACR = 12'h048;

  // Bit positions.
  localparam int CTRL_EN_BIT   = 0;
  localparam int CTRL_TXE_BIT  = 8;
  localparam int CTRL_RXE_BIT  = 9;
  localparam int LINE_FEN_BIT  = 4;
  localparam int RAW_RX_BIT    = 4;
  localparam int RAW_TX_BIT    = 5;
  localparam int FLAG_RXFE_BIT = 4;
  localparam int FLAG_RXFF_BIT = 6;
  localparam int FLAG_TXFE_BIT = 7;

  // Reset values.
  localparam logic [15:0] CTRL_RESET = 16'h0300;
  localparam logic [7:0]  FLAG_RESET = 8'h90;

  // One incoming request.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] reg_offset;
    logic [15:0] write_data;
    logic [7:0]  rx_byte;
  } req_t;

  // One response.
  typedef struct packed {
    logic [15:0] read_data;
    logic        irq_level;
    logic        tx_valid;
    logic [7:0]  tx_byte;
  } rsp_t;

  // Control from the register file to the FIFO.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] push_data;
    logic       fen;
  } fifo_ctl_t;

  // FIFO status: current and post-update occupancy flags and head byte.
  typedef struct packed {
    logic       empty;
    logic       full;
    logic       empty_next;
    logic       full_next;
    logic [7:0] head_data;
  } fifo_stat_t;

endpackage

// File: rtl/urxf_if.sv
// Valid/ready channel interfaces for requests and responses.
// Does not import urxf_pkg; the field widths mirror the ones it declares.
interface urxf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [11:0] reg_offset;
  logic [15:0] write_data;
  logic [7:0]  rx_byte;

  modport source (output valid, opcode, reg_offset, write_data, rx_byte, input ready);
  modport sink   (input valid, opcode, reg_offset, write_data, rx_byte, output ready);
endinterface

interface urxf_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        irq_level;
  logic        tx_valid;
  logic [7:0]  tx_byte;

  modport source (output valid, read_data, irq_level, tx_valid, tx_byte, input ready);
  modport sink   (input valid, read_data, irq_level, tx_valid, tx_byte, output ready);
endinterface

// File: rtl/urxf_fifo.sv
// Receive FIFO: circular byte store with head pointer, count and a
// registered head read port. Depends on urxf_pkg.
module urxf_fifo import urxf_pkg::*; #(
  parameter int DEPTH = RX_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  fifo_ctl_t  ctl,
  output fifo_stat_t stat
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [7:0]      mem [DEPTH];
  logic [PtrW-1:0] head;
  logic [PtrW-1:0] head_next;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic [PtrW:0]   wsum;
  logic [PtrW-1:0] waddr;
  logic [7:0]      head_q;

  // Pointer and occupancy arithmetic.
  always_comb begin
    wsum = {1'b0, head} + (PtrW + 1)'(count);
    if (wsum >= (PtrW + 1)'(DEPTH)) begin
      wsum = wsum - (PtrW + 1)'(DEPTH);
    end
    waddr = wsum[PtrW-1:0];

    head_next = head;
    if (ctl.pop) begin
      head_next = (head == PtrW'(DEPTH - 1)) ? '0 : head + 1'b1;
    end

    count_next = count;
    if (ctl.push) begin
      count_next = count + 1'b1;
    end else if (ctl.pop) begin
      count_next = count - 1'b1;
    end
  end

  // Status towards the register file; the limit is the depth or one entry.
  always_comb begin
    stat.empty      = (count == '0);
    stat.full       = ctl.fen ? (count >= CntW'(DEPTH)) : (count != '0);
    stat.empty_next = (count_next == '0);
    stat.full_next  = ctl.fen ? (count_next >= CntW'(DEPTH)) : (count_next != '0);
    stat.head_data  = head_q;
  end

  // Pointer and count registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // Storage write and registered read of the next head entry, with bypass
  // when a byte lands in an empty FIFO.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[waddr] <= ctl.push_data;
    end
    if (ctl.push && (waddr == head_next)) begin
      head_q <= ctl.push_data;
    end else begin
      head_q <= mem[head_next];
    end
  end

endmodule

// File: rtl/urxf_regs.sv
// Register file and request decoder: updates registers, steers the FIFO and
// forms the response for one request per cycle while go is high. Depends on urxf_pkg.
module urxf_regs import urxf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  req_t       item,
  input  fifo_stat_t fstat,
  output fifo_ctl_t  fctl,
  output rsp_t       result
);

  logic [7:0]  flag_word,    flag_word_next;
  logic [10:0] raw_status,   raw_status_next;
  logic [10:0] mask_word,    mask_word_next;
  logic [10:0] masked_word,  masked_word_next;
  logic [7:0]  line_ctrl,    line_ctrl_next;
  logic [15:0] ctrl_word,    ctrl_word_next;
  logic [15:0] int_divisor,  int_divisor_next;
  logic [5:0]  frac_divisor, frac_divisor_next;
  logic [5:0]  level_select, level_select_next;
  logic [15:0] dma_word,     dma_word_next;
  logic [15:0] irda_word,    irda_word_next;
  logic        recompute;
  logic        rx_enabled;
  logic [10:0] raw_pre;

  assign rx_enabled = ctrl_word[CTRL_EN_BIT] && ctrl_word[CTRL_RXE_BIT];

  // Decode the request and work out next register values and the response.
  always_comb begin
    flag_word_next    = flag_word;
    mask_word_next    = mask_word;
    line_ctrl_next    = line_ctrl;
    ctrl_word_next    = ctrl_word;
    int_divisor_next  = int_divisor;
    frac_divisor_next = frac_divisor;
    level_select_next = level_select;
    dma_word_next     = dma_word;
    irda_word_next    = irda_word;
    raw_pre           = raw_status;
    recompute         = 1'b0;

    fctl.push      = 1'b0;
    fctl.pop       = 1'b0;
    fctl.push_data = item.rx_byte;
    fctl.fen       = line_ctrl[LINE_FEN_BIT];

    result.read_data = '0;
    result.tx_valid  = 1'b0;
    result.tx_byte   = '0;

    unique case (item.opcode)
      OP_READ: begin
        unique case (item.reg_offset)
          OFF_DATA: begin
            fctl.pop  = go && !fstat.empty;
            recompute = 1'b1;
            result.read_data = fstat.empty ? '0 : {8'h00, fstat.head_data};
          end
          OFF_FLAG:  result.read_data = {8'h00, flag_word};
          OFF_IRDA:  result.read_data = irda_word;
          OFF_IBRD:  result.read_data = int_divisor;
          OFF_FBRD:  result.read_data = {10'h000, frac_divisor};
          OFF_LCR:   result.read_data = {8'h00, line_ctrl};
          OFF_CR:    result.read_data = ctrl_word;
          OFF_IFLS:  result.read_data = {10'h000, level_select};
          OFF_IMSC:  result.read_data = {5'h00, mask_word};
          OFF_RIS:   result.read_data = {5'h00, raw_status};
          OFF_MIS:   result.read_data = {5'h00, masked_word};
          OFF_DMACR: result.read_data = dma_word;
          default:   result.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (item.reg_offset)
          OFF_DATA: begin
            if (ctrl_word[CTRL_TXE_BIT]) begin
              raw_pre[RAW_TX_BIT] = 1'b1;
              recompute       = 1'b1;
              result.tx_valid = 1'b1;
              result.tx_byte  = item.write_data[7:0];
            end
          end
          OFF_IRDA:  irda_word_next    = item.write_data;
          OFF_IBRD:  int_divisor_next  = item.write_data;
          OFF_FBRD:  frac_divisor_next = item.write_data[5:0];
          OFF_LCR:   line_ctrl_next    = item.write_data[7:0];
          OFF_CR:    ctrl_word_next    = item.write_data;
          OFF_IFLS:  level_select_next = item.write_data[5:0];
          OFF_IMSC: begin
            mask_word_next = item.write_data[10:0];
            recompute      = 1'b1;
          end
          OFF_ICR: begin
            raw_pre   = raw_status & ~item.write_data[10:0];
            recompute = 1'b1;
          end
          OFF_DMACR: dma_word_next = item.write_data;
          default: begin
          end
        endcase
      end
      OP_RXBYTE: begin
        // Bytes received while disabled are dropped without a recompute.
        if (rx_enabled) begin
          fctl.push = go && !fstat.full;
          recompute = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Status refresh after FIFO, data, mask or clear accesses.
    raw_status_next  = raw_pre;
    masked_word_next = masked_word;
    if (recompute) begin
      raw_status_next[RAW_RX_BIT] = !fstat.empty_next;
      masked_word_next = raw_status_next & mask_word_next;
      flag_word_next   = '0;
      flag_word_next[FLAG_TXFE_BIT] = 1'b1;
      flag_word_next[FLAG_RXFE_BIT] = fstat.empty_next;
      flag_word_next[FLAG_RXFF_BIT] = fstat.full_next;
    end

    result.irq_level = (masked_word_next != '0);
  end

  // Register update, one request per cycle while go is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_word    <= FLAG_RESET;
      raw_status   <= '0;
      mask_word    <= '0;
      masked_word  <= '0;
      line_ctrl    <= '0;
      ctrl_word    <= CTRL_RESET;
      int_divisor  <= '0;
      frac_divisor <= '0;
      level_select <= '0;
      dma_word     <= '0;
      irda_word    <= '0;
    end else if (go) begin
      flag_word    <= flag_word_next;
      raw_status   <= raw_status_next;
      mask_word    <= mask_word_next;
      masked_word  <= masked_word_next;
      line_ctrl    <= line_ctrl_next;
      ctrl_word    <= ctrl_word_next;
      int_divisor  <= int_divisor_next;
      frac_divisor <= frac_divisor_next;
      level_select <= level_select_next;
      dma_word     <= dma_word_next;
      irda_word    <= irda_word_next;
    end
  end

endmodule

// File: rtl/uart_register_block_with_rx_fifo.sv
// Top level of the UART register block with receive FIFO: input register,
// register file, FIFO and response register. Depends on urxf_pkg, urxf_if,
// urxf_regs and urxf_fifo.
//
//   Channel | Direction | Payload
//   req     | in        | opcode, reg_offset, write_data, rx_byte
//   rsp     | out       | read_data, irq_level, tx_valid, tx_byte
//
// One request is taken per cycle while req.ready is high; its response is
// loaded from the input register into the response register and waits for rsp.
// Reset empties the FIFO and loads the register reset values at once.
// A stalled response holds the input register; req.ready drops only while
// both stages are full and rsp is not being taken.
module uart_register_block_with_rx_fifo import urxf_pkg::*; #(
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  urxf_req_if.sink  req,
  urxf_rsp_if.source rsp
);

  logic       s1_valid;
  req_t       s1_item;
  logic       advance;
  logic       go;
  logic       out_valid;
  rsp_t       out_q;
  rsp_t       result;
  fifo_ctl_t  fctl;
  fifo_stat_t fstat;

  // Flow control.
  assign advance   = !out_valid || rsp.ready;
  assign go        = s1_valid && advance;
  assign req.ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready) begin
      s1_item.opcode     <= req.opcode;
      s1_item.reg_offset <= req.reg_offset;
      s1_item.write_data <= req.write_data;
      s1_item.rx_byte    <= req.rx_byte;
    end
  end

  urxf_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .item   (s1_item),
    .fstat  (fstat),
    .fctl   (fctl),
    .result (result)
  );

  urxf_fifo #(
    .DEPTH (RX_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .ctl  (fctl),
    .stat (fstat)
  );

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_q <= result;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_q.read_data;
  assign rsp.irq_level = out_q.irq_level;
  assign rsp.tx_valid  = out_q.tx_valid;
  assign rsp.tx_byte   = out_q.tx_byte;

endmodule
